@@ rtl/u8dec_pkg.sv @@
// Shared types, constants and lookup tables for the UTF-8 stream decoder.
package u8dec_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CodeW  = 21;
	localparam int unsigned StateW = 4;
	localparam int unsigned ClassW = 4;
	localparam int unsigned WidthW = 2;

	localparam logic [StateW-1:0] ST_ACCEPT = 4'd0;
	localparam logic [StateW-1:0] ST_REJECT = 4'd1;
	localparam logic [StateW-1:0] ST_LAST   = 4'd8;

	localparam logic [CodeW-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CodeW-1:0] BMP_MAX        = 21'h00FFFF;
	localparam logic [CodeW-1:0] LATIN1_MAX     = 21'h0000FF;

	localparam logic [WidthW-1:0] WIDTH_ONE  = 2'd0;
	localparam logic [WidthW-1:0] WIDTH_TWO  = 2'd1;
	localparam logic [WidthW-1:0] WIDTH_FOUR = 2'd2;

	localparam logic [StateW-1:0] NEXT_TBL [0:8][0:11] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
	};

	typedef struct packed {
		logic [StateW-1:0] dfa_state;
		logic [CodeW-1:0]  partial_code;
		logic [WidthW-1:0] width_class;
	} dec_state_t;

	typedef struct packed {
		logic              emit;
		logic [CodeW-1:0]  code_point;
		logic              was_invalid;
		logic [WidthW-1:0] storage_width;
	} dec_result_t;

	function automatic logic [ClassW-1:0] byte_class(input logic [ByteW-1:0] b);
		logic [ClassW-1:0] cls;
		case (b) inside
			[8'h00:8'h7F]: cls = 4'd0;
			[8'h80:8'h8F]: cls = 4'd1;
			[8'h90:8'h9F]: cls = 4'd9;
			[8'hA0:8'hBF]: cls = 4'd7;
			[8'hC0:8'hC1]: cls = 4'd8;
			[8'hC2:8'hDF]: cls = 4'd2;
			8'hE0:         cls = 4'd10;
			8'hED:         cls = 4'd4;
			[8'hE1:8'hEF]: cls = 4'd3;
			8'hF0:         cls = 4'd11;
			[8'hF1:8'hF3]: cls = 4'd6;
			8'hF4:         cls = 4'd5;
			default:       cls = 4'd8;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/u8dec_step.sv @@
// One decode step: byte class, automaton transition, code point and width update.
module u8dec_step (
	input  logic [u8dec_pkg::ByteW-1:0] data_byte,
	input  logic                        end_of_string,
	input  u8dec_pkg::dec_state_t       cur,
	output u8dec_pkg::dec_state_t       nxt,
	output u8dec_pkg::dec_result_t      res
);
	import u8dec_pkg::*;

	logic [ClassW-1:0] cls;
	logic [StateW-1:0] row;
	logic [StateW-1:0] ns;
	logic [CodeW-1:0]  np;
	logic [ByteW-1:0]  lead_bits;
	logic              emit;
	logic              bad;
	logic [CodeW-1:0]  cp;
	logic [WidthW-1:0] nw;

	assign cls       = byte_class(data_byte);
	assign row       = (cur.dfa_state > ST_LAST) ? ST_REJECT : cur.dfa_state;
	assign lead_bits = (8'hFF >> cls) & data_byte;
	assign np        = (row != ST_ACCEPT) ? {cur.partial_code[CodeW-7:0], data_byte[5:0]}
	                                      : {{(CodeW-ByteW){1'b0}}, lead_bits};
	assign ns        = NEXT_TBL[row][cls];

	always_comb begin
		emit = 1'b0;
		bad  = 1'b0;
		cp   = np;
		if (ns == ST_ACCEPT) begin
			emit = 1'b1;
		end else if (ns == ST_REJECT || end_of_string) begin
			emit = 1'b1;
			bad  = 1'b1;
			cp   = REPLACEMENT_CP;
		end
	end

	always_comb begin
		nw = cur.width_class;
		if (emit) begin
			if (cp > BMP_MAX) begin
				nw = WIDTH_FOUR;
			end else if (cp > LATIN1_MAX && cur.width_class == WIDTH_ONE) begin
				nw = WIDTH_TWO;
			end
		end
	end

	always_comb begin
		res.emit          = emit;
		res.code_point    = cp;
		res.was_invalid   = bad;
		res.storage_width = nw;
		if (end_of_string) begin
			nxt.dfa_state    = ST_ACCEPT;
			nxt.partial_code = '0;
			nxt.width_class  = WIDTH_ONE;
		end else begin
			nxt.dfa_state    = bad ? ST_ACCEPT : ns;
			nxt.partial_code = np;
			nxt.width_class  = nw;
		end
	end

endmodule

@@ rtl/utf8_stream_decoder_unit.sv @@
// Top level of the streaming UTF-8 decoder: input register, decode step, result register.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+------------------------------------------------
//  byte in  | byte_valid  | byte_ready  | data_byte, end_of_string
//  char out | char_valid  | char_ready  | code_point, was_invalid, storage_width, last
//
// One byte per cycle unless a held result stalls; bytes go via input and result registers.
// State loop (class lookup, transition table, 6-bit shift) is combinational into state_q.
// arst_n clears the automaton, width class and both valid flags.
// A held result stalls only bytes that produce a result; mid-sequence bytes still advance.
module utf8_stream_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_ready,
	input  logic [u8dec_pkg::ByteW-1:0]  data_byte,
	input  logic                         end_of_string,
	output logic                         char_valid,
	input  logic                         char_ready,
	output logic [u8dec_pkg::CodeW-1:0]  code_point,
	output logic                         was_invalid,
	output logic [u8dec_pkg::WidthW-1:0] storage_width,
	output logic                         last
);
	import u8dec_pkg::*;

	logic              valid_s1;
	logic [ByteW-1:0]  data_byte_s1;
	logic              eos_s1;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	dec_result_t       res;
	logic              out_valid_q;
	logic [CodeW-1:0]  code_point_q;
	logic              was_invalid_q;
	logic [WidthW-1:0] storage_width_q;
	logic              last_q;
	logic              advance;
	logic              load_out;

	u8dec_step u_step (
		.data_byte     (data_byte_s1),
		.end_of_string (eos_s1),
		.cur           (state_q),
		.nxt           (state_nxt),
		.res           (res)
	);

	assign advance    = valid_s1 && (!res.emit || !out_valid_q || char_ready);
	assign load_out   = advance && res.emit;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_byte_s1 <= data_byte;
			eos_s1       <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dfa_state    <= ST_ACCEPT;
			state_q.partial_code <= '0;
			state_q.width_class  <= WIDTH_ONE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			code_point_q    <= res.code_point;
			was_invalid_q   <= res.was_invalid;
			storage_width_q <= res.storage_width;
			last_q          <= eos_s1;
		end
	end

	assign char_valid    = out_valid_q;
	assign code_point    = code_point_q;
	assign was_invalid   = was_invalid_q;
	assign storage_width = storage_width_q;
	assign last          = last_q;

endmodule

@@ verif/tb_utf8_stream_decoder_unit.sv @@
// Testbench for utf8_stream_decoder_unit: random and directed UTF-8 byte strings, scoreboard check.
`timescale 1ns / 100ps

import u8dec_pkg::*;

class char_scoreboard;
	typedef enum logic [3:0] {
		CL_ASCII    = 4'd0,
		CL_CONT_LO  = 4'd1,
		CL_LEAD2    = 4'd2,
		CL_LEAD3    = 4'd3,
		CL_LEAD_ED  = 4'd4,
		CL_LEAD_F4  = 4'd5,
		CL_LEAD4    = 4'd6,
		CL_CONT_HI  = 4'd7,
		CL_BAD      = 4'd8,
		CL_CONT_MID = 4'd9,
		CL_LEAD_E0  = 4'd10,
		CL_LEAD_F0  = 4'd11
	} byte_class_e;

	typedef enum logic [3:0] {
		S_ACCEPT   = 4'd0,
		S_REJECT   = 4'd1,
		S_NEED1    = 4'd2,
		S_NEED2    = 4'd3,
		S_AFTER_E0 = 4'd4,
		S_AFTER_ED = 4'd5,
		S_AFTER_F0 = 4'd6,
		S_NEED3    = 4'd7,
		S_AFTER_F4 = 4'd8
	} dfa_state_e;

	typedef struct packed {
		logic [CodeW-1:0]  code_point;
		logic              was_invalid;
		logic [WidthW-1:0] storage_width;
		logic              last;
	} char_t;

	char_t             expected_chars[$];
	dfa_state_e        state;
	logic [CodeW-1:0]  partial;
	logic [WidthW-1:0] width_class;
	int                errors;

	function new();
		errors = 0;
		restart();
	endfunction

	function void restart();
		state       = S_ACCEPT;
		partial     = '0;
		width_class = WIDTH_ONE;
	endfunction

	static function byte_class_e classify(logic [ByteW-1:0] b);
		if (b < 8'h80) return CL_ASCII;
		if (b < 8'h90) return CL_CONT_LO;
		if (b < 8'hA0) return CL_CONT_MID;
		if (b < 8'hC0) return CL_CONT_HI;
		if (b < 8'hC2) return CL_BAD;
		if (b < 8'hE0) return CL_LEAD2;
		if (b == 8'hE0) return CL_LEAD_E0;
		if (b == 8'hED) return CL_LEAD_ED;
		if (b < 8'hF0) return CL_LEAD3;
		if (b == 8'hF0) return CL_LEAD_F0;
		if (b < 8'hF4) return CL_LEAD4;
		if (b == 8'hF4) return CL_LEAD_F4;
		return CL_BAD;
	endfunction

	static function dfa_state_e advance(dfa_state_e row, byte_class_e cls);
		dfa_state_e nxt;
		logic       cont;
		cont = (cls == CL_CONT_LO) || (cls == CL_CONT_MID) || (cls == CL_CONT_HI);
		nxt  = S_REJECT;
		case (row)
			S_ACCEPT: begin
				case (cls)
					CL_ASCII:   nxt = S_ACCEPT;
					CL_LEAD2:   nxt = S_NEED1;
					CL_LEAD3:   nxt = S_NEED2;
					CL_LEAD4:   nxt = S_NEED3;
					CL_LEAD_E0: nxt = S_AFTER_E0;
					CL_LEAD_ED: nxt = S_AFTER_ED;
					CL_LEAD_F0: nxt = S_AFTER_F0;
					CL_LEAD_F4: nxt = S_AFTER_F4;
					default:    nxt = S_REJECT;
				endcase
			end
			S_NEED1:    if (cont) nxt = S_ACCEPT;
			S_NEED2:    if (cont) nxt = S_NEED1;
			S_NEED3:    if (cont) nxt = S_NEED2;
			S_AFTER_E0: if (cls == CL_CONT_HI) nxt = S_NEED1;
			S_AFTER_ED: if (cls == CL_CONT_LO || cls == CL_CONT_MID) nxt = S_NEED1;
			S_AFTER_F0: if (cls == CL_CONT_MID || cls == CL_CONT_HI) nxt = S_NEED2;
			S_AFTER_F4: if (cls == CL_CONT_LO) nxt = S_NEED2;
			default:    nxt = S_REJECT;
		endcase
		return nxt;
	endfunction

	function void note_byte(logic [ByteW-1:0] b, logic eos);
		byte_class_e cls;
		char_t       res;
		cls = classify(b);
		if (state != S_ACCEPT) begin
			partial = {partial[CodeW-7:0], b[5:0]};
		end else begin
			partial      = '0;
			partial[7:0] = b & (8'hFF >> cls);
		end
		state = advance(state, cls);
		if (state == S_ACCEPT) begin
			res.code_point  = partial;
			res.was_invalid = 1'b0;
		end else if (state == S_REJECT || eos) begin
			// rejected byte or sequence cut off by end of string
			res.code_point  = REPLACEMENT_CP;
			res.was_invalid = 1'b1;
			state           = S_ACCEPT;
		end else begin
			return;
		end
		if (res.code_point > BMP_MAX)
			width_class = WIDTH_FOUR;
		else if (res.code_point > LATIN1_MAX && width_class == WIDTH_ONE)
			width_class = WIDTH_TWO;
		res.storage_width = width_class;
		res.last          = eos;
		expected_chars.push_back(res);
		if (eos)
			restart();
	endfunction

	function void check_char(logic [CodeW-1:0] cp, logic bad, logic [WidthW-1:0] w, logic lst);
		char_t ref_c;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected transfer, code_point %h", $time, cp);
			errors++;
			return;
		end
		ref_c = expected_chars.pop_front();
		if (cp !== ref_c.code_point) begin
			$display("%0t: code_point expected %h actual %h", $time, ref_c.code_point, cp);
			errors++;
		end
		if (bad !== ref_c.was_invalid) begin
			$display("%0t: was_invalid expected %b actual %b", $time, ref_c.was_invalid, bad);
			errors++;
		end
		if (w !== ref_c.storage_width) begin
			$display("%0t: storage_width expected %0d actual %0d", $time, ref_c.storage_width, w);
			errors++;
		end
		if (lst !== ref_c.last) begin
			$display("%0t: last expected %b actual %b", $time, ref_c.last, lst);
			errors++;
		end
	endfunction
endclass

module tb_utf8_stream_decoder_unit;
	localparam int IDLE_PCT     = 37;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              byte_valid    = 1'b0;
	logic              byte_ready;
	logic [ByteW-1:0]  data_byte     = '0;
	logic              end_of_string = 1'b0;
	logic              char_valid;
	logic              char_ready    = 1'b0;
	logic [CodeW-1:0]  code_point;
	logic              was_invalid;
	logic [WidthW-1:0] storage_width;
	logic              last;

	logic              no_gaps = 1'b0;
	int                sent_count = 0;
	logic [ByteW-1:0]  str_bytes[$];
	char_scoreboard    sb;

	utf8_stream_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.code_point    (code_point),
		.was_invalid   (was_invalid),
		.storage_width (storage_width),
		.last          (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready)
			sb.check_char(code_point, was_invalid, storage_width, last);
	end

	initial begin
		forever begin
			@(negedge clk);
			char_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		int dead_cycles;
		dead_cycles = 0;
		while (dead_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (char_valid && char_ready))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// called and returns at a falling edge
	task automatic send_byte(input logic [ByteW-1:0] b, input logic eos);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid    <= 1'b1;
		data_byte     <= b;
		end_of_string <= eos;
		do @(posedge clk); while (!byte_ready);
		sb.note_byte(b, eos);
		sent_count++;
		@(negedge clk);
	endtask

	function automatic void add_char(input int nbytes);
		logic [CodeW-1:0] cp;
		case (nbytes)
			1:       cp = CodeW'($urandom_range(21'h7F, 0));
			2:       cp = CodeW'($urandom_range(21'h7FF, 21'h80));
			3:       cp = CodeW'($urandom_range(21'hFFFF, 21'h800));
			default: cp = CodeW'($urandom_range(21'h10FFFF, 21'h10000));
		endcase
		case (nbytes)
			1: str_bytes.push_back(cp[7:0]);
			2: begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// mostly well-formed characters; some noise, truncated and corrupted sequences
	task automatic send_string();
		int nchars;
		int top;
		int kind;
		int roll;
		int first;
		str_bytes.delete();
		nchars = $urandom_range(8, 1);
		top    = $urandom_range(4, 1);
		for (int c = 0; c < nchars; c++) begin
			kind  = $urandom_range(top, 1);
			roll  = $urandom_range(99);
			first = str_bytes.size();
			if (roll < 8) begin
				str_bytes.push_back(ByteW'($urandom_range(255)));
			end else begin
				add_char(kind);
				if (roll < 14 && kind > 1)
					repeat ($urandom_range(kind - 1, 1)) void'(str_bytes.pop_back());
				else if (roll < 20)
					str_bytes[$urandom_range(str_bytes.size() - 1, first)] =
						ByteW'($urandom_range(255));
			end
		end
		foreach (str_bytes[i])
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
	endtask

	initial begin
		int  random_start;
		bit  paused;
		paused = 1'b0;
		sb     = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// length boundaries, width class 0 -> 1
		send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b1);
		send_byte(8'h41, 1'b1);
		// three and four byte extremes, width class up to 2
		send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
		// rejected bytes, then truncated at end of string
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
		send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hE1, 1'b0); send_byte(8'h80, 1'b1);

		byte_valid <= 1'b0;
		do @(negedge clk); while (sb.expected_chars.size() != 0);

		random_start = sent_count;
		while (sent_count - random_start < RANDOM_ITEMS) begin
			no_gaps <= (sent_count - random_start >= 700) && (sent_count - random_start < 1000);
			if (!paused && sent_count - random_start >= 1400) begin
				paused = 1'b1;
				byte_valid <= 1'b0;
				do @(negedge clk); while (sb.expected_chars.size() != 0);
			end
			send_string();
		end
		byte_valid <= 1'b0;

		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
